>>> hw/rtl/pmea_pkg.sv
// ----------------------------------------------------------------------------
// pmea_pkg
// types, layout codes and register indexes of the packed matrix element
// address generator
// ----------------------------------------------------------------------------
package pmea_pkg;

   localparam int MAX_DIM   = 256;
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int DIM_W     = IDX_W + 1;
   localparam int ADDR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // layout codes
   localparam logic [2:0] MODE_GENERAL   = 3'd0;
   localparam logic [2:0] MODE_DIAGONAL  = 3'd1;
   localparam logic [2:0] MODE_TRIDIAG   = 3'd2;
   localparam logic [2:0] MODE_SYMMETRIC = 3'd3;
   localparam logic [2:0] MODE_UPPER_TRI = 3'd4;
   localparam logic [2:0] MODE_LOWER_TRI = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LAYOUT_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE_VIEW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT      = 2'd3;

   typedef struct packed {
      logic [IDX_W-1:0] row_index;
      logic [IDX_W-1:0] col_index;
   } req_data_type;

   typedef struct packed {
      logic [ADDR_W-1:0] word_address;
      logic              is_stored;
   } rsp_data_type;

   typedef struct packed {
      logic [2:0]       layout_mode;
      logic             transpose_view;
      logic [DIM_W-1:0] row_count;
      logic [DIM_W-1:0] col_count;
   } cfg_type;

endpackage

>>> hw/rtl/pmea_addr_calc.sv
// ----------------------------------------------------------------------------
// pmea_addr_calc
// address and stored flag of one element for the configured layout
// ----------------------------------------------------------------------------
module pmea_addr_calc
   import pmea_pkg::*;
(
   input  cfg_type      cfg,
   input  req_data_type req,
   output rsp_data_type rsp
);

   logic [IDX_W-1:0]    r;
   logic [IDX_W-1:0]    c;
   logic [IDX_W-1:0]    lo;
   logic [IDX_W-1:0]    hi;
   logic                r_le_c;
   logic [IDX_W-1:0]    mul_a;
   logic [DIM_W-1:0]    mul_b;
   logic [2*IDX_W:0]    prod;
   logic [2*IDX_W:0]    lo_sq;
   logic [ADDR_W-1:0]   tri_num;
   logic [ADDR_W-1:0]   tri_addr;
   logic [ADDR_W-1:0]   row_m1;
   logic [IDX_W:0]      r_p1;
   logic [IDX_W:0]      c_p1;

   // optional index swap
   assign r      = cfg.transpose_view ? req.col_index : req.row_index;
   assign c      = cfg.transpose_view ? req.row_index : req.col_index;
   assign r_le_c = (r <= c);
   assign lo     = r_le_c ? r : c;
   assign hi     = r_le_c ? c : r;

   // one multiplier shared by row-major and packed triangle strides
   assign mul_a = (cfg.layout_mode == MODE_GENERAL) ? r : lo;
   assign mul_b = (cfg.layout_mode == MODE_GENERAL) ? cfg.col_count : cfg.row_count;
   assign prod  = (2*IDX_W+1)'(mul_a) * (2*IDX_W+1)'(mul_b);

   // lo*(lo+1)/2
   assign lo_sq    = (2*IDX_W+1)'(lo) * ((2*IDX_W+1)'(lo) + (2*IDX_W+1)'(1));
   assign tri_num  = ADDR_W'(lo_sq >> 1);
   assign tri_addr = ADDR_W'(prod) + ADDR_W'(hi) - tri_num;

   assign row_m1 = ADDR_W'(cfg.row_count) - ADDR_W'(1);
   assign r_p1   = (IDX_W+1)'(r) + (IDX_W+1)'(1);
   assign c_p1   = (IDX_W+1)'(c) + (IDX_W+1)'(1);

   always_comb begin
      rsp.word_address = '0;
      rsp.is_stored    = 1'b0;
      case (cfg.layout_mode)
         MODE_GENERAL: begin
            rsp.word_address = ADDR_W'(prod) + ADDR_W'(c);
            rsp.is_stored    = 1'b1;
         end
         MODE_DIAGONAL: begin
            if (r == c) begin
               rsp.word_address = ADDR_W'(r);
               rsp.is_stored    = 1'b1;
            end
         end
         MODE_TRIDIAG: begin
            if ((IDX_W+1)'(c) == r_p1) begin
               rsp.word_address = ADDR_W'(r);
               rsp.is_stored    = 1'b1;
            end else if (c == r) begin
               rsp.word_address = row_m1 + ADDR_W'(r);
               rsp.is_stored    = 1'b1;
            end else if ((IDX_W+1)'(r) == c_p1) begin
               rsp.word_address = (row_m1 << 1) + ADDR_W'(r);
               rsp.is_stored    = 1'b1;
            end
         end
         MODE_SYMMETRIC: begin
            rsp.word_address = tri_addr;
            rsp.is_stored    = 1'b1;
         end
         MODE_UPPER_TRI: begin
            if (r_le_c) begin
               rsp.word_address = tri_addr;
               rsp.is_stored    = 1'b1;
            end
         end
         MODE_LOWER_TRI: begin
            if (c <= r) begin
               rsp.word_address = tri_addr;
               rsp.is_stored    = 1'b1;
            end
         end
         default: begin
            rsp.word_address = '0;
            rsp.is_stored    = 1'b0;
         end
      endcase
   end

endmodule

>>> hw/rtl/packed_matrix_element_address_top.sv
// ----------------------------------------------------------------------------
// packed_matrix_element_address_top
// word address and stored flag of a matrix element in a packed store
// ----------------------------------------------------------------------------
// channel   ports                               direction
// request   req_valid  req_ready  req_data      in
// response  rsp_valid  rsp_ready  rsp_data      out
// config    csr_we  csr_index  csr_wdata        in, write only
//
// one transaction per cycle while the response side is ready; an input register,
// then one multiply-add-subtract pass into the result register
// reset is synchronous and active high, it empties both stages and sets the
// layout registers to general, no transpose, one by one
// a stalled response holds the result register; the input stage keeps
// taking transactions as long as it can move forward
// ----------------------------------------------------------------------------
module packed_matrix_element_address_top
   import pmea_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_data_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_data_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_data_type s1_data_ff;
   logic         s2_valid_ff;
   logic         s2_valid_in;
   rsp_data_type s2_data_ff;
   rsp_data_type calc_rsp;
   logic         s1_adv;
   logic         req_take;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LAYOUT_MODE:    cfg_in.layout_mode    = csr_wdata[2:0];
            CSR_TRANSPOSE_VIEW: cfg_in.transpose_view = csr_wdata[0];
            CSR_ROW_COUNT:      cfg_in.row_count      = csr_wdata;
            CSR_COL_COUNT:      cfg_in.col_count      = csr_wdata;
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.layout_mode    <= MODE_GENERAL;
         cfg_ff.transpose_view <= 1'b0;
         cfg_ff.row_count      <= DIM_W'(1);
         cfg_ff.col_count      <= DIM_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline control
   assign s1_adv      = s1_valid_ff && (!s2_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_adv;
   assign req_take    = req_valid && req_ready;
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_adv);
   assign s2_valid_in = s1_adv || (s2_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (s1_adv) begin
         s2_data_ff <= calc_rsp;
      end
   end

   pmea_addr_calc u_addr_calc (
      .cfg (cfg_ff),
      .req (s1_data_ff),
      .rsp (calc_rsp)
   );

   assign rsp_valid = s2_valid_ff;
   assign rsp_data  = s2_data_ff;

endmodule

>>> hw/rtl/pmea_checker.sv
// ----------------------------------------------------------------------------
// pmea_checker
// port level checks of the packed matrix element address generator
// ----------------------------------------------------------------------------
module pmea_checker
   import pmea_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_data_type         req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_data_type         rsp_data
);

   // stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // an accepted transaction is followed by a valid response, its own or one still queued
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("accepted transaction lost");

   // structural zero carries address zero
   a_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_stored |-> rsp_data.word_address == '0)
      else $error("structural zero with nonzero address");

endmodule

bind packed_matrix_element_address_top pmea_checker u_pmea_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/tb_packed_matrix_element_address_top.sv
// ----------------------------------------------------------------------------
// tb_packed_matrix_element_address_top
// self-checking testbench of the packed matrix element address generator
//
// every layout code is run under several register settings, including zero
// and oversized strides that make the address wrap. a short directed part
// covers the index extremes and the near-diagonal cases of each layout, then
// random phases mix near-diagonal and uniform indices. the request side
// sends in bursts with gaps and the response side stalls on a pattern of its
// own. each accepted request is predicted at acceptance and the response
// fields are compared in order
// ----------------------------------------------------------------------------
module tb_packed_matrix_element_address_top;
   import pmea_pkg::*;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_data_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_data_type         rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_wdata = '0;

   cfg_type       layout_cfg;
   req_data_type  req_pending_q[$];
   rsp_data_type  addr_expect_q[$];
   rsp_data_type  want_rsp;
   bit            req_taken   = 1'b0;
   int            fail_count  = 0;
   int            burst_left  = 0;
   int            gap_left    = 0;
   int            stall_mode  = 0;
   int            stall_left  = 0;
   int            ready_tick  = 0;
   int            random_sent = 0;

   packed_matrix_element_address_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [31:0] packed_offset(input logic [31:0] lo, input logic [31:0] hi,
                                                 input logic [31:0] stride);
      return lo * stride + hi - (lo * (lo + 32'd1)) / 32'd2;
   endfunction

   function automatic rsp_data_type predict_address(input cfg_type cfg, input req_data_type item);
      logic [31:0]  r;
      logic [31:0]  c;
      logic [31:0]  rc;
      logic [31:0]  cc;
      logic [31:0]  addr;
      logic         stored;
      rsp_data_type res;
      r = 32'(item.row_index);
      c = 32'(item.col_index);
      if (cfg.transpose_view) begin
         r = 32'(item.col_index);
         c = 32'(item.row_index);
      end
      rc = 32'(cfg.row_count);
      cc = 32'(cfg.col_count);
      addr = '0;
      stored = 1'b0;
      case (cfg.layout_mode)
         MODE_GENERAL: begin
            addr = r * cc + c;
            stored = 1'b1;
         end
         MODE_DIAGONAL: begin
            if (r == c) begin
               addr = r;
               stored = 1'b1;
            end
         end
         MODE_TRIDIAG: begin
            if (c == r + 32'd1) begin
               addr = r;
               stored = 1'b1;
            end else if (c == r) begin
               addr = (rc - 32'd1) + r;
               stored = 1'b1;
            end else if (r == c + 32'd1) begin
               addr = 32'd2 * (rc - 32'd1) + r;
               stored = 1'b1;
            end
         end
         MODE_SYMMETRIC: begin
            addr = (r <= c) ? packed_offset(r, c, rc) : packed_offset(c, r, rc);
            stored = 1'b1;
         end
         MODE_UPPER_TRI: begin
            if (r <= c) begin
               addr = packed_offset(r, c, rc);
               stored = 1'b1;
            end
         end
         MODE_LOWER_TRI: begin
            if (c <= r) begin
               addr = packed_offset(c, r, rc);
               stored = 1'b1;
            end
         end
         default: ;
      endcase
      if (!stored)
         addr = '0;
      res.word_address = addr[ADDR_W-1:0];
      res.is_stored = stored;
      return res;
   endfunction

   function automatic req_data_type make_req(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
      req_data_type item;
      item.row_index = r;
      item.col_index = c;
      return item;
   endfunction

   function automatic req_data_type random_req();
      logic [IDX_W-1:0] r;
      logic [IDX_W-1:0] c;
      int               kind;
      kind = $urandom_range(0, 9);
      r = IDX_W'($urandom_range(0, 255));
      if (kind < 4)
         c = IDX_W'($urandom_range(0, 255));
      else if (kind < 8)
         c = r + IDX_W'($urandom_range(0, 2)) - IDX_W'(1);
      else begin
         r = IDX_W'($urandom_range(0, 15));
         c = IDX_W'($urandom_range(0, 15));
      end
      return make_req(r, c);
   endfunction

   function automatic logic [DIM_W-1:0] random_dim();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return DIM_W'(1);
      else if (pick == 1)
         return DIM_W'(256);
      else if (pick == 2)
         return DIM_W'($urandom_range(0, 511));
      else
         return DIM_W'($urandom_range(1, 256));
   endfunction

   task automatic note_failure(input string msg);
      if (fail_count < 10)
         $display("mismatch: %s", msg);
      fail_count++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_LAYOUT_MODE:    layout_cfg.layout_mode = value[2:0];
         CSR_TRANSPOSE_VIEW: layout_cfg.transpose_view = value[0];
         CSR_ROW_COUNT:      layout_cfg.row_count = value;
         CSR_COL_COUNT:      layout_cfg.col_count = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input logic [DIM_W-1:0] mode, input logic [DIM_W-1:0] flip,
                            input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
      write_reg(CSR_LAYOUT_MODE, mode);
      write_reg(CSR_TRANSPOSE_VIEW, flip);
      write_reg(CSR_ROW_COUNT, rows);
      write_reg(CSR_COL_COUNT, cols);
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (req_pending_q.size() != 0 || req_valid || addr_expect_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // request driver, bursts with random gaps
   always @(negedge clock) begin
      if (req_valid && !req_taken) begin
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (req_pending_q.size() != 0) begin
         req_valid <= 1'b1;
         req_data <= req_pending_q.pop_front();
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // response stall pattern
   always @(negedge clock) begin
      ready_tick <= ready_tick + 1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= ($urandom_range(0, 4) != 0);
         default: rsp_ready <= (ready_tick % 4 == 0);
      endcase
   end

   // monitor: predict on request transaction, check on response transaction
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready)
            addr_expect_q.push_back(predict_address(layout_cfg, req_data));
         if (rsp_valid && rsp_ready) begin
            if (addr_expect_q.size() == 0) begin
               note_failure($sformatf("unexpected response addr=%0d stored=%0d",
                                      rsp_data.word_address, rsp_data.is_stored));
            end else begin
               want_rsp = addr_expect_q.pop_front();
               if (rsp_data.word_address !== want_rsp.word_address)
                  note_failure($sformatf("word_address expected %0d got %0d",
                                         want_rsp.word_address, rsp_data.word_address));
               if (rsp_data.is_stored !== want_rsp.is_stored)
                  note_failure($sformatf("is_stored expected %0d got %0d",
                                         want_rsp.is_stored, rsp_data.is_stored));
            end
         end
      end
   end

   initial begin
      int n;
      layout_cfg.layout_mode = MODE_GENERAL;
      layout_cfg.transpose_view = 1'b0;
      layout_cfg.row_count = DIM_W'(1);
      layout_cfg.col_count = DIM_W'(1);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, index extremes
      req_pending_q.push_back(make_req(8'd0, 8'd0));
      req_pending_q.push_back(make_req(8'd255, 8'd255));
      req_pending_q.push_back(make_req(8'd0, 8'd255));
      req_pending_q.push_back(make_req(8'd255, 8'd0));
      wait_idle();

      // near-diagonal cases of every layout code, wide stride and zero row count
      for (int m = 0; m < 8; m++) begin
         configure(DIM_W'(m), DIM_W'(m % 2), (m == 2) ? DIM_W'(0) : DIM_W'(256),
                   (m == 0) ? DIM_W'(511) : DIM_W'(256));
         req_pending_q.push_back(make_req(8'd7, 8'd7));
         req_pending_q.push_back(make_req(8'd7, 8'd8));
         req_pending_q.push_back(make_req(8'd8, 8'd7));
         if (m == 0)
            req_pending_q.push_back(make_req(8'd255, 8'd255));
         wait_idle();
      end

      // random phases
      while (random_sent < 500) begin
         configure(DIM_W'($urandom_range(0, 511)), DIM_W'($urandom_range(0, 511)),
                   random_dim(), random_dim());
         n = $urandom_range(20, 60);
         for (int i = 0; i < n; i++)
            req_pending_q.push_back(random_req());
         random_sent += n;
         wait_idle();
      end

      repeat (10) @(posedge clock);
      fail_count += addr_expect_q.size();
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
